[rtl/msss_pkg.sv]
// Shared constants, codes and control bundles of the minimum variance shift search.
package msss_pkg;

  localparam int RECORD_DEPTH = 32768;
  localparam int MAX_SHIFTS   = 16384;

  localparam int SAMPLE_W = 16;
  localparam int BLEN_W   = 13;
  localparam int LEAD_W   = 16;
  localparam int SCNT_W   = 15;
  localparam int SHIFT_W  = 14;
  localparam int CFG_W    = 16;
  localparam int CIDX_W   = 2;

  localparam int DIFF_W   = SAMPLE_W + 1;
  localparam int SQ_W     = 2 * DIFF_W;
  localparam int SUMD_W   = 30;
  localparam int SUMSQ_W  = 46;
  localparam int SPREAD_W = 58;
  localparam int MUL_W    = 30;
  localparam int PROD_W   = 2 * MUL_W;
  localparam int SPLIT    = 23;

  localparam logic [BLEN_W-1:0] BLEN_RESET = BLEN_W'(3000);
  localparam logic [LEAD_W-1:0] LEAD_RESET = LEAD_W'(23000);
  localparam logic [SCNT_W-1:0] SCNT_RESET = SCNT_W'(5000);

  typedef enum logic [CIDX_W-1:0] {
    REG_BASELINE_LEN = 2'd0,
    REG_NOISE_LEAD   = 2'd1,
    REG_SHIFT_COUNT  = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    OP_NONE    = 3'd0,
    OP_SQ_SUM  = 3'd1,
    OP_SCALE_LO = 3'd2,
    OP_SCALE_HI = 3'd3,
    OP_ADD_HI  = 3'd4,
    OP_TAKE    = 3'd5,
    OP_COMPARE = 3'd6
  } dp_op_t;

  typedef struct packed {
    logic               issue;
    logic               clear;
    dp_op_t             op;
    logic [SHIFT_W-1:0] shift;
  } dp_ctrl_t;

  typedef struct packed {
    logic idle;
    logic report;
    logic bad;
  } seq_stat_t;

endpackage

[rtl/msss_store.sv]
// Sample record memory with one write port and two registered read ports.
module msss_store #(
  parameter int RECORD_DEPTH = msss_pkg::RECORD_DEPTH
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [$clog2(RECORD_DEPTH)-1:0]       wr_addr,
  input  logic signed [msss_pkg::SAMPLE_W-1:0]  wr_data,
  input  logic                                  rd_en,
  input  logic [$clog2(RECORD_DEPTH)-1:0]       rd_addr_a,
  input  logic [$clog2(RECORD_DEPTH)-1:0]       rd_addr_b,
  output logic signed [msss_pkg::SAMPLE_W-1:0]  rd_data_a,
  output logic signed [msss_pkg::SAMPLE_W-1:0]  rd_data_b
);

  logic signed [msss_pkg::SAMPLE_W-1:0] mem [RECORD_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

[rtl/msss_datapath.sv]
// Difference pipeline, shared multiplier, accumulators and best-spread compare.
module msss_datapath (
  input  logic                                  clk,
  input  logic                                  rst,
  input  msss_pkg::dp_ctrl_t                    ctrl,
  input  logic signed [msss_pkg::SAMPLE_W-1:0]  b_data,
  input  logic signed [msss_pkg::SAMPLE_W-1:0]  n_data,
  input  logic [msss_pkg::BLEN_W-1:0]           baseline_len,
  output logic                                  busy,
  output logic [msss_pkg::SHIFT_W-1:0]          best_shift,
  output logic [msss_pkg::SPREAD_W-1:0]         best_spread
);

  logic                                 v_rd;
  logic                                 v_mul;
  logic signed [msss_pkg::DIFF_W-1:0]   diff;
  logic signed [msss_pkg::DIFF_W-1:0]   d_q;
  logic [msss_pkg::DIFF_W-1:0]          abs_d;
  logic [msss_pkg::SUMD_W-1:0]          abs_sum;
  logic [msss_pkg::MUL_W-1:0]           mul_a;
  logic [msss_pkg::MUL_W-1:0]           mul_b;
  logic [msss_pkg::PROD_W-1:0]          prod;
  logic signed [msss_pkg::SUMD_W-1:0]   sum_d;
  logic [msss_pkg::SUMSQ_W-1:0]         sum_sq;
  logic [msss_pkg::SPREAD_W-1:0]        spread;
  logic [msss_pkg::SPREAD_W-1:0]        least;
  logic [msss_pkg::SHIFT_W-1:0]         best;

  assign diff    = msss_pkg::DIFF_W'(b_data) - msss_pkg::DIFF_W'(n_data);
  assign abs_d   = diff[msss_pkg::DIFF_W-1] ? msss_pkg::DIFF_W'(-diff) : msss_pkg::DIFF_W'(diff);
  assign abs_sum = sum_d[msss_pkg::SUMD_W-1] ? msss_pkg::SUMD_W'(-sum_d)
                                             : msss_pkg::SUMD_W'(sum_d);

  always_comb begin
    unique case (ctrl.op)
      msss_pkg::OP_SQ_SUM: begin
        mul_a = msss_pkg::MUL_W'(abs_sum);
        mul_b = msss_pkg::MUL_W'(abs_sum);
      end
      msss_pkg::OP_SCALE_LO: begin
        mul_a = msss_pkg::MUL_W'(baseline_len);
        mul_b = msss_pkg::MUL_W'(sum_sq[msss_pkg::SPLIT-1:0]);
      end
      msss_pkg::OP_SCALE_HI: begin
        mul_a = msss_pkg::MUL_W'(baseline_len);
        mul_b = msss_pkg::MUL_W'(sum_sq[msss_pkg::SUMSQ_W-1:msss_pkg::SPLIT]);
      end
      default: begin
        mul_a = msss_pkg::MUL_W'(abs_d);
        mul_b = msss_pkg::MUL_W'(abs_d);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_rd  <= 1'b0;
      v_mul <= 1'b0;
    end else begin
      v_rd  <= ctrl.issue;
      v_mul <= v_rd;
    end
  end

  always_ff @(posedge clk) begin
    d_q  <= diff;
    prod <= mul_a * mul_b;
    if (ctrl.clear) begin
      sum_d  <= '0;
      sum_sq <= '0;
    end else if (v_mul) begin
      sum_d  <= sum_d + msss_pkg::SUMD_W'(d_q);
      sum_sq <= sum_sq + msss_pkg::SUMSQ_W'(prod[msss_pkg::SQ_W-1:0]);
    end
    unique case (ctrl.op)
      msss_pkg::OP_SCALE_LO: spread <= msss_pkg::SPREAD_W'(0) - prod[msss_pkg::SPREAD_W-1:0];
      msss_pkg::OP_SCALE_HI: spread <= spread + prod[msss_pkg::SPREAD_W-1:0];
      msss_pkg::OP_ADD_HI: begin
        spread <= spread + msss_pkg::SPREAD_W'({prod, {msss_pkg::SPLIT{1'b0}}});
      end
      msss_pkg::OP_TAKE: begin
        least <= spread;
        best  <= ctrl.shift;
      end
      msss_pkg::OP_COMPARE: begin
        if (spread < least) begin
          least <= spread;
          best  <= ctrl.shift;
        end
      end
      default: ;
    endcase
  end

  assign busy        = v_rd | v_mul;
  assign best_shift  = best;
  assign best_spread = least;

endmodule

[rtl/msss_ctrl.sv]
// Search sequencer: window guard, read address walk, shift loop and result handoff.
module msss_ctrl #(
  parameter int RECORD_DEPTH = msss_pkg::RECORD_DEPTH
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic                                  out_free,
  input  logic                                  dp_busy,
  input  logic [msss_pkg::BLEN_W-1:0]           baseline_len,
  input  logic [msss_pkg::LEAD_W-1:0]           noise_lead,
  input  logic [msss_pkg::SCNT_W-1:0]           shift_count,
  input  logic [$clog2(RECORD_DEPTH)-1:0]       wp,
  input  logic [$clog2(RECORD_DEPTH+1)-1:0]     fill,
  output logic [$clog2(RECORD_DEPTH)-1:0]       rd_addr_b,
  output logic [$clog2(RECORD_DEPTH)-1:0]       rd_addr_n,
  output msss_pkg::dp_ctrl_t                    dp_ctrl,
  output msss_pkg::seq_stat_t                   stat
);

  localparam int AW     = $clog2(RECORD_DEPTH);
  localparam int FILL_W = $clog2(RECORD_DEPTH + 1);
  localparam int CMP_W  = (FILL_W > msss_pkg::LEAD_W + 1) ? FILL_W : msss_pkg::LEAD_W + 1;

  typedef enum logic [9:0] {
    S_IDLE    = 10'b0000000001,
    S_CHECK   = 10'b0000000010,
    S_RUN     = 10'b0000000100,
    S_DRAIN   = 10'b0000001000,
    S_FIN_SQ  = 10'b0000010000,
    S_FIN_LO  = 10'b0000100000,
    S_FIN_HI  = 10'b0001000000,
    S_FIN_ADD = 10'b0010000000,
    S_CMP     = 10'b0100000000,
    S_REPORT  = 10'b1000000000
  } state_t;

  state_t                         state;
  state_t                         state_next;
  logic                           bad;
  logic [AW-1:0]                  ra;
  logic [AW-1:0]                  rn;
  logic [AW-1:0]                  base_addr;
  logic [AW-1:0]                  noise_base;
  logic [msss_pkg::BLEN_W-1:0]    i_cnt;
  logic [msss_pkg::SHIFT_W-1:0]   s_cnt;
  logic [msss_pkg::SCNT_W-1:0]    shifts;
  logic [CMP_W-1:0]               fill_c;
  logic [CMP_W-1:0]               lead_c;
  logic [CMP_W-1:0]               len_c;
  logic [CMP_W-1:0]               shifts_c;
  logic                           guard_bad;
  logic                           last_i;
  logic                           last_s;

  function automatic logic [AW-1:0] back_addr(input logic [AW-1:0] ptr,
                                               input logic [CMP_W-1:0] back);
    logic [CMP_W:0] delta;
    delta = (CMP_W+1)'(ptr) - (CMP_W+1)'(back);
    if (delta[CMP_W]) begin
      delta = delta + (CMP_W+1)'(RECORD_DEPTH);
    end
    return delta[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] next_addr(input logic [AW-1:0] a);
    return (a == AW'(RECORD_DEPTH - 1)) ? '0 : a + 1'b1;
  endfunction

  assign shifts = (shift_count > msss_pkg::SCNT_W'(msss_pkg::MAX_SHIFTS))
                  ? msss_pkg::SCNT_W'(msss_pkg::MAX_SHIFTS) : shift_count;
  assign fill_c   = CMP_W'(fill);
  assign lead_c   = CMP_W'(noise_lead);
  assign len_c    = CMP_W'(baseline_len);
  assign shifts_c = CMP_W'(shifts);

  assign guard_bad = (baseline_len == '0) || (noise_lead == '0) || (shifts == '0) ||
                     (fill_c < lead_c) || (fill_c < len_c) ||
                     (lead_c + CMP_W'(1) < shifts_c + len_c);

  assign last_i = (i_cnt + msss_pkg::BLEN_W'(1)) == baseline_len;
  assign last_s = (msss_pkg::SCNT_W'(s_cnt) + msss_pkg::SCNT_W'(1)) == shifts;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:    if (start) state_next = S_CHECK;
      S_CHECK:   state_next = guard_bad ? S_REPORT : S_RUN;
      S_RUN:     if (last_i) state_next = S_DRAIN;
      S_DRAIN:   if (!dp_busy) state_next = S_FIN_SQ;
      S_FIN_SQ:  state_next = S_FIN_LO;
      S_FIN_LO:  state_next = S_FIN_HI;
      S_FIN_HI:  state_next = S_FIN_ADD;
      S_FIN_ADD: state_next = S_CMP;
      S_CMP:     state_next = last_s ? S_REPORT : S_RUN;
      S_REPORT:  if (out_free) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      bad   <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CHECK) begin
        bad <= guard_bad;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_CHECK: begin
        ra         <= back_addr(wp, len_c);
        base_addr  <= back_addr(wp, len_c);
        rn         <= back_addr(wp, lead_c);
        noise_base <= back_addr(wp, lead_c);
        i_cnt      <= '0;
        s_cnt      <= '0;
      end
      S_RUN: begin
        ra    <= next_addr(ra);
        rn    <= next_addr(rn);
        i_cnt <= i_cnt + 1'b1;
      end
      S_CMP: begin
        if (!last_s) begin
          s_cnt      <= s_cnt + 1'b1;
          noise_base <= next_addr(noise_base);
          rn         <= next_addr(noise_base);
          ra         <= base_addr;
          i_cnt      <= '0;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    dp_ctrl.issue = (state == S_RUN);
    dp_ctrl.clear = (state == S_CHECK) || ((state == S_CMP) && !last_s);
    dp_ctrl.shift = s_cnt;
    unique case (state)
      S_FIN_SQ:  dp_ctrl.op = msss_pkg::OP_SQ_SUM;
      S_FIN_LO:  dp_ctrl.op = msss_pkg::OP_SCALE_LO;
      S_FIN_HI:  dp_ctrl.op = msss_pkg::OP_SCALE_HI;
      S_FIN_ADD: dp_ctrl.op = msss_pkg::OP_ADD_HI;
      S_CMP:     dp_ctrl.op = (s_cnt == '0) ? msss_pkg::OP_TAKE : msss_pkg::OP_COMPARE;
      default:   dp_ctrl.op = msss_pkg::OP_NONE;
    endcase
  end

  assign rd_addr_b   = ra;
  assign rd_addr_n   = rn;
  assign stat.idle   = (state == S_IDLE);
  assign stat.report = (state == S_REPORT) && out_free;
  assign stat.bad    = bad;

  a_start_when_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> state == S_IDLE)
    else $error("search started while a search was running");

  a_drained_before_finish: assert property (@(posedge clk) disable iff (rst)
    state == S_FIN_SQ |-> !dp_busy)
    else $error("finish step began with samples still in the pipeline");

  a_sample_index_in_window: assert property (@(posedge clk) disable iff (rst)
    state == S_RUN |-> i_cnt < baseline_len)
    else $error("sample index ran past the baseline window");

  a_shift_in_range: assert property (@(posedge clk) disable iff (rst)
    state == S_CMP |-> msss_pkg::SCNT_W'(s_cnt) < shifts)
    else $error("shift counter ran past the shift count");

endmodule

[rtl/min_variance_shift_search.sv]
// Top level of the minimum variance shift search: registers, record bookkeeping, output word.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid / in_ready       sample, last_sample
//   out      output     out_valid / out_ready     best_shift, best_spread, status
//   cfg      input      cfg_write                 cfg_index, cfg_data
//
// A word without last_sample is stored and the block is ready again at once.
// A word with last_sample drops in_ready; the result word follows a search over S shifts
// (S clamped shift count, L = baseline_len): per shift L reads, a drain, 4 finish steps
// and a compare. A record too short for the windows is reported with status 1.
// A finished result waits in the output register while samples keep loading; a further result
// holds in_ready low until that word leaves. Reset is synchronous and restores the registers.
module min_variance_shift_search #(
  parameter int RECORD_DEPTH = msss_pkg::RECORD_DEPTH
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [msss_pkg::CIDX_W-1:0]           cfg_index,
  input  logic [msss_pkg::CFG_W-1:0]            cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [msss_pkg::SAMPLE_W-1:0]  sample,
  input  logic                                  last_sample,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [msss_pkg::SHIFT_W-1:0]          best_shift,
  output logic [msss_pkg::SPREAD_W-1:0]         best_spread,
  output logic                                  status
);

  localparam int AW     = $clog2(RECORD_DEPTH);
  localparam int FILL_W = $clog2(RECORD_DEPTH + 1);

  logic [msss_pkg::BLEN_W-1:0]          baseline_len;
  logic [msss_pkg::LEAD_W-1:0]          noise_lead;
  logic [msss_pkg::SCNT_W-1:0]          shift_count;
  logic [AW-1:0]                        wp;
  logic [FILL_W-1:0]                    fill;
  logic                                 accept;
  logic                                 out_free;
  logic                                 dp_busy;
  logic [AW-1:0]                        rd_addr_b;
  logic [AW-1:0]                        rd_addr_n;
  logic signed [msss_pkg::SAMPLE_W-1:0] b_data;
  logic signed [msss_pkg::SAMPLE_W-1:0] n_data;
  logic [msss_pkg::SHIFT_W-1:0]         dp_best_shift;
  logic [msss_pkg::SPREAD_W-1:0]        dp_best_spread;
  msss_pkg::dp_ctrl_t                   dp_ctrl;
  msss_pkg::seq_stat_t                  stat;

  assign in_ready = stat.idle;
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      baseline_len <= msss_pkg::BLEN_RESET;
      noise_lead   <= msss_pkg::LEAD_RESET;
      shift_count  <= msss_pkg::SCNT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        msss_pkg::REG_BASELINE_LEN: baseline_len <= cfg_data[msss_pkg::BLEN_W-1:0];
        msss_pkg::REG_NOISE_LEAD:   noise_lead   <= cfg_data[msss_pkg::LEAD_W-1:0];
        msss_pkg::REG_SHIFT_COUNT:  shift_count  <= cfg_data[msss_pkg::SCNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= '0;
      fill <= '0;
    end else if (accept) begin
      wp <= (wp == AW'(RECORD_DEPTH - 1)) ? '0 : wp + 1'b1;
      if (fill != FILL_W'(RECORD_DEPTH)) begin
        fill <= fill + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stat.report) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.report) begin
      best_shift  <= stat.bad ? '0 : dp_best_shift;
      best_spread <= stat.bad ? '0 : dp_best_spread;
      status      <= stat.bad;
    end
  end

  msss_store #(
    .RECORD_DEPTH(RECORD_DEPTH)
  ) u_store (
    .clk       (clk),
    .wr_en     (accept),
    .wr_addr   (wp),
    .wr_data   (sample),
    .rd_en     (dp_ctrl.issue),
    .rd_addr_a (rd_addr_b),
    .rd_addr_b (rd_addr_n),
    .rd_data_a (b_data),
    .rd_data_b (n_data)
  );

  msss_ctrl #(
    .RECORD_DEPTH(RECORD_DEPTH)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (accept && last_sample),
    .out_free     (out_free),
    .dp_busy      (dp_busy),
    .baseline_len (baseline_len),
    .noise_lead   (noise_lead),
    .shift_count  (shift_count),
    .wp           (wp),
    .fill         (fill),
    .rd_addr_b    (rd_addr_b),
    .rd_addr_n    (rd_addr_n),
    .dp_ctrl      (dp_ctrl),
    .stat         (stat)
  );

  msss_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (dp_ctrl),
    .b_data       (b_data),
    .n_data       (n_data),
    .baseline_len (baseline_len),
    .busy         (dp_busy),
    .best_shift   (dp_best_shift),
    .best_spread  (dp_best_spread)
  );

endmodule

[tb/min_variance_shift_search_tb.sv]
// Self-checking testbench for the minimum variance shift search, with its own search predictor.
module min_variance_shift_search_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RESET_CYCLES   = 10;
  localparam int SETTLE_CYCLES  = 16;
  localparam int HOLD_CYCLES    = 3000;
  localparam int RANDOM_WORDS   = 750;
  localparam int WATCHDOG_LIMIT = 700000;

  typedef struct {
    logic signed [msss_pkg::SAMPLE_W-1:0] value;
    logic                                 last;
  } sample_word_t;

  typedef struct {
    logic [msss_pkg::SHIFT_W-1:0]  shift;
    logic [msss_pkg::SPREAD_W-1:0] spread;
    logic                          status;
  } search_result_t;

  typedef enum int {RX_OPEN, RX_RANDOM, RX_SPARSE} rx_mode_t;

  logic                                 clk         = 1'b0;
  logic                                 rst         = 1'b1;
  logic                                 cfg_write   = 1'b0;
  logic [msss_pkg::CIDX_W-1:0]          cfg_index   = '0;
  logic [msss_pkg::CFG_W-1:0]           cfg_data    = '0;
  logic                                 in_valid    = 1'b0;
  logic                                 in_ready;
  logic signed [msss_pkg::SAMPLE_W-1:0] sample      = '0;
  logic                                 last_sample = 1'b0;
  logic                                 out_valid;
  logic                                 out_ready   = 1'b0;
  logic [msss_pkg::SHIFT_W-1:0]         best_shift;
  logic [msss_pkg::SPREAD_W-1:0]        best_spread;
  logic                                 status;

  min_variance_shift_search i_dut (.*);

  always #4ns clk = ~clk;

  // Predictor copy of the record and the registers.
  logic signed [msss_pkg::SAMPLE_W-1:0] record_mem [msss_pkg::RECORD_DEPTH];
  int record_wp   = 0;
  int record_fill = 0;
  int blen_cfg    = int'(msss_pkg::BLEN_RESET);
  int lead_cfg    = int'(msss_pkg::LEAD_RESET);
  int scnt_cfg    = int'(msss_pkg::SCNT_RESET);

  sample_word_t   queued_words[$];
  search_result_t predicted_results[$];

  int fail_count      = 0;
  int results_checked = 0;
  int short_results   = 0;
  int words_accepted  = 0;
  int widest_shift    = 0;
  int idle_cycles     = 0;

  bit       in_took    = 1'b0;
  int       burst_left = 0;
  int       gap_left   = 0;
  rx_mode_t rx_mode    = RX_OPEN;
  int       mode_left  = 0;
  int       hold_left  = 0;
  bit       hold_req   = 1'b0;
  bit       hold_seen  = 1'b0;

  logic signed [msss_pkg::SAMPLE_W-1:0] walk_level = '0;

  function automatic int record_at(int back);
    return int'(record_mem[(record_wp + msss_pkg::RECORD_DEPTH - back) %
                           msss_pkg::RECORD_DEPTH]);
  endfunction

  function automatic longint unsigned window_spread(int shift);
    longint          diff_sum;
    longint unsigned sq_sum;
    longint unsigned mag;
    int              d;
    diff_sum = 0;
    sq_sum   = 0;
    for (int i = 0; i < blen_cfg; i++) begin
      d = record_at(blen_cfg - i) - record_at(lead_cfg - shift - i);
      diff_sum += d;
      sq_sum   += longint'(d) * longint'(d);
    end
    mag = (diff_sum < 0) ? -diff_sum : diff_sum;
    return longint'(blen_cfg) * sq_sum - mag * mag;
  endfunction

  function automatic void absorb_sample(logic signed [msss_pkg::SAMPLE_W-1:0] value,
                                        logic last);
    search_result_t  res;
    int              shifts;
    int              best;
    longint unsigned least;
    longint unsigned sp;
    record_mem[record_wp] = value;
    record_wp = (record_wp + 1) % msss_pkg::RECORD_DEPTH;
    if (record_fill < msss_pkg::RECORD_DEPTH) record_fill++;
    if (!last) return;
    shifts     = (scnt_cfg > msss_pkg::MAX_SHIFTS) ? msss_pkg::MAX_SHIFTS : scnt_cfg;
    best       = 0;
    least      = 0;
    res.status = 1'b1;
    if (blen_cfg != 0 && lead_cfg != 0 && shifts != 0 && record_fill >= lead_cfg &&
        record_fill >= blen_cfg && lead_cfg >= shifts + blen_cfg - 1) begin
      res.status = 1'b0;
      least = window_spread(0);
      for (int s = 1; s < shifts; s++) begin
        sp = window_spread(s);
        if (sp < least) begin
          least = sp;
          best  = s;
        end
      end
    end
    res.shift  = msss_pkg::SHIFT_W'(best);
    res.spread = msss_pkg::SPREAD_W'(least);
    predicted_results = {predicted_results, res};
  endfunction

  function automatic void flag_error(string msg);
    fail_count++;
    if (fail_count <= 10) $display("ERROR at %0t ns: %s", $time, msg);
  endfunction

  function automatic logic signed [msss_pkg::SAMPLE_W-1:0] pick_sample(int style);
    logic signed [msss_pkg::SAMPLE_W-1:0] v;
    case (style)
      0: v = msss_pkg::SAMPLE_W'($urandom);
      1: v = msss_pkg::SAMPLE_W'(int'($urandom_range(0, 16)) - 8);
      2: begin
        case ($urandom_range(0, 3))
          0:       v = 16'sh8000;
          1:       v = 16'sh7fff;
          2:       v = '0;
          default: v = '1;
        endcase
      end
      default: begin
        walk_level = walk_level + msss_pkg::SAMPLE_W'(int'($urandom_range(0, 64)) - 32);
        v = walk_level;
      end
    endcase
    return v;
  endfunction

  function automatic void push_word(logic signed [msss_pkg::SAMPLE_W-1:0] value, logic last);
    sample_word_t w;
    w.value = value;
    w.last  = last;
    queued_words = {queued_words, w};
  endfunction

  // A run of plain samples closed by a trigger word.
  function automatic void push_run(int run_len, int style);
    repeat (run_len) push_word(pick_sample(style), 1'b0);
    push_word(pick_sample(style), 1'b1);
  endfunction

  task automatic write_reg(msss_pkg::cfg_reg_t idx, logic [msss_pkg::CFG_W-1:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      msss_pkg::REG_BASELINE_LEN: blen_cfg = int'(value[msss_pkg::BLEN_W-1:0]);
      msss_pkg::REG_NOISE_LEAD:   lead_cfg = int'(value);
      msss_pkg::REG_SHIFT_COUNT:  scnt_cfg = int'(value[msss_pkg::SCNT_W-1:0]);
      default: ;
    endcase
  endtask

  task automatic set_windows(int blen, int lead, int scnt);
    write_reg(msss_pkg::REG_BASELINE_LEN, msss_pkg::CFG_W'(blen));
    write_reg(msss_pkg::REG_NOISE_LEAD, msss_pkg::CFG_W'(lead));
    write_reg(msss_pkg::REG_SHIFT_COUNT, msss_pkg::CFG_W'(scnt));
  endtask

  // Waits until every word is in and every result is out, then lets the block go quiet.
  task automatic settle();
    while (queued_words.size() != 0 || in_valid || predicted_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(negedge clk) begin
    sample_word_t w;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (queued_words.size() != 0) begin
        w = queued_words.pop_front();
        in_valid    <= 1'b1;
        sample      <= w.value;
        last_sample <= w.last;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 250)
                                                   : $urandom_range(1, 12);
          gap_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(0, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = rx_mode_t'($urandom_range(0, 2));
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      case (rx_mode)
        RX_OPEN:   out_ready <= 1'b1;
        RX_RANDOM: out_ready <= 1'($urandom_range(0, 1));
        default:   out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    search_result_t want;
    bit             out_took;
    if (rst) begin
      in_took     = 1'b0;
      idle_cycles = 0;
    end else begin
      in_took  = in_valid && in_ready;
      out_took = out_valid && out_ready;
      if (in_took) begin
        words_accepted++;
        absorb_sample(sample, last_sample);
      end
      if (out_took) begin
        results_checked++;
        if (predicted_results.size() == 0) begin
          flag_error($sformatf("unexpected result: shift %0d spread %0d status %0b",
                               best_shift, best_spread, status));
        end else begin
          want = predicted_results.pop_front();
          if (want.status) short_results++;
          if (int'(want.shift) > widest_shift) widest_shift = int'(want.shift);
          if (want.shift !== best_shift || want.spread !== best_spread ||
              want.status !== status)
            flag_error($sformatf({"result %0d: expected shift %0d spread %0d status %0b, ",
                                  "got shift %0d spread %0d status %0b"},
                                 results_checked, want.shift, want.spread, want.status,
                                 best_shift, best_spread, status));
        end
      end
      if (in_took || out_took) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("Timeout after %0d cycles with no word moving.", idle_cycles);
          $display("Verification failed");
          $finish;
        end
      end
    end
  end

  initial begin
    int blen;
    int lead;
    int scnt;
    int run_len;
    int phase;
    int sent;
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    // Reset registers with an almost empty record: too short for the windows.
    push_word(16'sh8000, 1'b0);
    push_word(16'sh7fff, 1'b0);
    push_word(16'sh0000, 1'b0);
    push_word(-16'sd1, 1'b1);
    settle();
    set_windows(1, 1, 1);
    push_word(16'sh1234, 1'b1);
    settle();
    set_windows(2, 5, 4);
    push_word(16'sh8000, 1'b0);
    push_word(16'sh7fff, 1'b0);
    push_word(16'sh8000, 1'b0);
    push_word(16'sh7fff, 1'b0);
    push_word(16'sh0000, 1'b1);
    settle();
    // The last noise window would run past the trigger.
    set_windows(3, 4, 3);
    push_word(16'sd5, 1'b1);
    settle();
    set_windows(0, 8, 2);
    push_word(16'sd9, 1'b1);
    settle();
    set_windows(4, 0, 2);
    push_word(-16'sd9, 1'b1);
    settle();
    set_windows(4, 8, 0);
    push_word(16'sd3, 1'b1);
    settle();
    set_windows(2, 20, msss_pkg::MAX_SHIFTS);
    push_word(16'sd4, 1'b1);
    settle();
    set_windows(4, msss_pkg::RECORD_DEPTH, 1);
    push_word(16'sd6, 1'b1);
    settle();
    // A flat record gives equal spreads everywhere, so shift zero must win.
    set_windows(3, 8, 4);
    repeat (7) push_word(16'sd7, 1'b0);
    push_word(16'sd7, 1'b1);

    sent  = 0;
    phase = 0;
    while (sent < RANDOM_WORDS) begin
      settle();
      blen = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
      scnt = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
      lead = scnt + blen - 1 + $urandom_range(0, 20);
      case ($urandom_range(0, 11))
        0: lead = $urandom_range(1, scnt + blen - 1);
        1: blen = 0;
        2: lead = 0;
        3: scnt = 0;
        default: ;
      endcase
      set_windows(blen, lead, scnt);
      if (phase == 3) hold_req = ~hold_req;
      repeat ($urandom_range(2, 6)) begin
        if ($urandom_range(0, 5) == 0) begin
          run_len = $urandom_range(1, 10);
          repeat (run_len) push_word(pick_sample($urandom_range(0, 3)), 1'b0);
          sent += run_len;
        end
        run_len = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 40);
        push_run(run_len, $urandom_range(0, 3));
        sent += run_len + 1;
      end
      phase++;
    end

    // The largest shift count is clamped before the window guard; the record is too short.
    settle();
    set_windows(2, msss_pkg::MAX_SHIFTS + 1, 32767);
    push_run(0, 0);
    settle();
    // A baseline window of up to 4096 words, with a noise lead one word longer than it.
    blen = (record_fill - 1 > 4096) ? 4096 : record_fill - 1;
    set_windows(blen, blen + 1, 2);
    push_run(0, 3);
    settle();

    $display("Run moved %0d sample words and checked %0d search results (%0d short-record).",
             words_accepted, results_checked, short_results);
    $display("Largest best shift seen: %0d; errors: %0d.", widest_shift, fail_count);
    if (fail_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

[sim.f]
rtl/msss_pkg.sv
rtl/msss_store.sv
rtl/msss_datapath.sv
rtl/msss_ctrl.sv
rtl/min_variance_shift_search.sv
tb/min_variance_shift_search_tb.sv
